// File: hw/rtl/buddy_pkg.sv
// buddy_pkg: shared constants for the buddy block allocator
// command and status codes, table entry layout
// no dependencies
`timescale 1ns / 1ps
package buddy_pkg;
	localparam int LEVELS_DEF = 10;
	localparam int MIN_LOG2_DEF = 4;

	localparam int ADDR_W = 14;
	localparam int REQ_W = 15;
	localparam int ORD_OUT_W = 4;
	localparam int ST_W = 2;
	localparam int ENT_W = 6;
	localparam int CUR_W = 5;

	localparam int E_START = 5;
	localparam int E_FREE = 4;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd2;
endpackage

// File: hw/rtl/buddy_block_allocator.sv
// buddy_block_allocator: buddy allocator with the block table in one on-chip memory
// depends on buddy_pkg
`timescale 1ns / 1ps
// Commands are taken when start is high and busy is low; each command gives exactly one
// beat on done with block_address, block_order and status, and the receiver cannot stall.
// After reset the block runs a clearing pass through the block table with busy high,
// one write per entry. A free reads the freed block's entry, then its buddy's for each
// merge step, up to LEVELS. An allocate walks the blocks of the pool in address order,
// one table read per block, then splits the chosen block one level at a time; the table's
// single read port and the read-to-address dependence of the walk keep the walk serial.
// Bad sizes and bad free addresses are answered straight from the idle state.
module buddy_block_allocator
	import buddy_pkg::*;
#(
	parameter int LEVELS = LEVELS_DEF,
	parameter int MIN_BLOCK_LOG2 = MIN_LOG2_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 command,
	input  logic [REQ_W-1:0]     request_bytes,
	input  logic [ADDR_W-1:0]    free_address,
	output logic                 done,
	output logic [ADDR_W-1:0]    block_address,
	output logic [ORD_OUT_W-1:0] block_order,
	output logic [ST_W-1:0]      status
);
	localparam int NBLK = 1 << LEVELS;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_SPLIT = 4'd3;
	localparam logic [3:0] S_FCHK  = 4'd4;
	localparam logic [3:0] S_MCHK  = 4'd5;
	localparam logic [3:0] S_FFIN  = 4'd6;

	logic [ENT_W-1:0] mem [NBLK];
	logic [ENT_W-1:0] rd;
	logic [LEVELS-1:0] ra, wa;
	logic [ENT_W-1:0] wd;
	logic we;

	logic [3:0] state_q;
	logic [LEVELS:0] clr_q, scan_q;
	logic [LEVELS-1:0] idx_q, best_q;
	logic [CUR_W-1:0] k_q, cur_q, best_ord_q;
	logic found_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd <= mem[ra];
	end

	// size rounding and free address checks
	logic [31:0] bytes_w, addr_w, idx_w;
	logic [CUR_W-1:0] k_calc;
	logic too_big, bad_free;
	always_comb begin
		bytes_w = {{(32-REQ_W){1'b0}}, request_bytes};
		addr_w = {{(32-ADDR_W){1'b0}}, free_address};
		idx_w = addr_w >> MIN_BLOCK_LOG2;
		too_big = bytes_w > (32'd1 << (LEVELS + MIN_BLOCK_LOG2));
		bad_free = ((addr_w & ((32'd1 << MIN_BLOCK_LOG2) - 32'd1)) != 32'd0)
			|| (idx_w >= NBLK);
		k_calc = '0;
		for (int j = 0; j < LEVELS; j++) begin
			if ((32'd1 << (MIN_BLOCK_LOG2 + j)) < bytes_w)
				k_calc = k_calc + 1'b1;
		end
	end

	logic [CUR_W-1:0] rd_ord, ncur;
	logic [LEVELS:0] one_w, step, nxt;
	logic [LEVELS-1:0] bud, nidx, lo_half;
	logic rd_ok, better;
	always_comb begin
		rd_ord = {1'b0, rd[3:0]};
		one_w = {{LEVELS{1'b0}}, 1'b1};
		step = rd[E_START] ? (one_w << rd_ord) : one_w;
		nxt = scan_q + step;
		rd_ok = rd[E_START] && rd[E_FREE];
		better = rd_ok && (rd_ord >= k_q) && (!found_q || rd_ord < best_ord_q);
		bud = idx_q ^ LEVELS'(one_w << cur_q);
		nidx = (bud < idx_q) ? bud : idx_q;
		ncur = cur_q + 1'b1;
		lo_half = best_q + LEVELS'(one_w << (cur_q - 1'b1));
	end

	logic [3:0] state_d;
	always_comb begin
		state_d = state_q;
		ra = '0;
		we = 1'b0;
		wa = '0;
		wd = '0;
		unique case (state_q)
			S_CLR: begin
				we = 1'b1;
				wa = clr_q[LEVELS-1:0];
				wd = (clr_q == '0) ?
					{1'b1, 1'b1, 4'(LEVELS)} : '0;
				if (clr_q == (LEVELS+1)'(NBLK - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (command == CMD_ALLOC) begin
						if (request_bytes != '0 && !too_big)
							state_d = S_SCAN;
					end else if (!bad_free) begin
						ra = idx_w[LEVELS-1:0];
						state_d = S_FCHK;
					end
				end
			end
			S_SCAN: begin
				if (nxt[LEVELS])
					state_d = S_SPLIT;
				else
					ra = nxt[LEVELS-1:0];
			end
			S_SPLIT: begin
				if (!found_q)
					state_d = S_IDLE;
				else if (cur_q > k_q) begin
					we = 1'b1;
					wa = lo_half;
					wd = {1'b1, 1'b1, 4'(cur_q - 1'b1)};
				end else begin
					we = 1'b1;
					wa = best_q;
					wd = {1'b1, 1'b0, 4'(k_q)};
					state_d = S_IDLE;
				end
			end
			S_FCHK: begin
				if (!rd[E_START] || rd[E_FREE])
					state_d = S_IDLE;
				else if (rd_ord < CUR_W'(LEVELS)) begin
					ra = idx_q ^ LEVELS'(one_w << rd_ord);
					state_d = S_MCHK;
				end else
					state_d = S_FFIN;
			end
			S_MCHK: begin
				if (rd_ok && rd_ord == cur_q) begin
					we = 1'b1;
					wa = (bud < idx_q) ? idx_q : bud;
					if (ncur < CUR_W'(LEVELS))
						ra = nidx ^ LEVELS'(one_w << ncur);
					else
						state_d = S_FFIN;
				end else begin
					we = 1'b1;
					wa = idx_q;
					wd = {1'b1, 1'b1, 4'(cur_q)};
					state_d = S_IDLE;
				end
			end
			S_FFIN: begin
				we = 1'b1;
				wa = idx_q;
				wd = {1'b1, 1'b1, 4'(cur_q)};
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			done <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= 1'b0;
			unique case (state_q)
				S_CLR: clr_q <= clr_q + 1'b1;
				S_IDLE: begin
					if (start) begin
						if (command == CMD_ALLOC) begin
							k_q <= k_calc;
							scan_q <= '0;
							found_q <= 1'b0;
							if (request_bytes == '0) begin
								done <= 1'b1;
								block_address <= '0;
								block_order <= '0;
								status <= ST_INVALID;
							end else if (too_big) begin
								done <= 1'b1;
								block_address <= '0;
								block_order <= '0;
								status <= ST_NO_SPACE;
							end
						end else begin
							idx_q <= idx_w[LEVELS-1:0];
							block_address <= free_address;
							if (bad_free) begin
								done <= 1'b1;
								block_order <= '0;
								status <= ST_INVALID;
							end
						end
					end
				end
				S_SCAN: begin
					scan_q <= nxt;
					if (better) begin
						found_q <= 1'b1;
						best_q <= scan_q[LEVELS-1:0];
						best_ord_q <= rd_ord;
						cur_q <= rd_ord;
					end
				end
				S_SPLIT: begin
					if (!found_q) begin
						done <= 1'b1;
						block_address <= '0;
						block_order <= '0;
						status <= ST_NO_SPACE;
					end else if (cur_q > k_q)
						cur_q <= cur_q - 1'b1;
					else begin
						done <= 1'b1;
						block_address <= ADDR_W'({{(32-LEVELS){1'b0}}, best_q}
							<< MIN_BLOCK_LOG2);
						block_order <= ORD_OUT_W'(k_q);
						status <= ST_OK;
					end
				end
				S_FCHK: begin
					done <= 1'b1;
					cur_q <= rd_ord;
					if (!rd[E_START] || rd[E_FREE]) begin
						block_order <= '0;
						status <= ST_INVALID;
					end else begin
						block_order <= rd[3:0];
						status <= ST_OK;
					end
				end
				S_MCHK: begin
					if (rd_ok && rd_ord == cur_q) begin
						idx_q <= nidx;
						cur_q <= ncur;
					end
				end
				S_FFIN: ;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_resp: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted command neither busy nor answered");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status == ST_OK || status == ST_NO_SPACE || status == ST_INVALID)
		else $error("bad status code");
	a_fail_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> block_order == '0)
		else $error("failed command with nonzero order");
	a_no_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |=> !done)
		else $error("beat during clearing pass");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> !scan_q[LEVELS])
		else $error("walk beyond pool");
`endif
endmodule
